>>> sv/swrr_pkg.sv
// Shared types, codes and saturation helper for the smooth weighted round-robin selector.
`default_nettype none

package swrr_pkg;

    localparam int RW_W  = 13;  // running weight, two's complement
    localparam int IDX_W = 3;   // target index
    localparam int TOT_W = 11;  // sum of up to eight 8-bit weights
    localparam int ST_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W = 64;

    localparam logic signed [RW_W-1:0] RW_MAX = 13'sd4095;
    localparam logic signed [RW_W-1:0] RW_MIN = -13'sd4096;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_TARGETS = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_HEALTHY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 2'd1;

    localparam logic [CFG_W-1:0] WEIGHTS_RST = 64'h0101_0101_0101_0101;
    localparam logic [3:0]       COUNT_RST   = 4'd8;

    // Best-so-far token passed from cell to cell during a scan.
    typedef struct packed {
        logic                   found;
        logic signed [RW_W-1:0] best_val;
        logic [IDX_W-1:0]       best_idx;
        logic [TOT_W-1:0]       total;
    } t_token;

    // Winner update broadcast to all cells at the end of a scan.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [TOT_W-1:0] total;
    } t_apply;

    function automatic logic signed [RW_W-1:0] sat_rw(input logic signed [RW_W:0] v);
        logic signed [RW_W:0] hi;
        logic signed [RW_W:0] lo;
        hi = {RW_MAX[RW_W-1], RW_MAX};
        lo = {RW_MIN[RW_W-1], RW_MIN};
        if (v > hi) begin
            sat_rw = RW_MAX;
        end else if (v < lo) begin
            sat_rw = RW_MIN;
        end else begin
            sat_rw = v[RW_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/swrr_cell.sv
// One target cell: holds its running weight and updates the passing best-so-far token.
`default_nettype none

module swrr_cell
    import swrr_pkg::*;
#(
    parameter int WEIGHT_BITS = 8,
    parameter int INDEX       = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_clear,
    input  wire logic [WEIGHT_BITS-1:0] i_weight,
    input  wire logic                   i_in_use,
    input  wire logic                   i_healthy,
    input  wire logic                   i_valid,
    input  wire t_token                 i_token,
    input  wire t_apply                 i_apply,
    output logic                        o_valid,
    output t_token                      o_token
);

    logic signed [RW_W-1:0] r_rw;
    logic signed [RW_W-1:0] n_rw;
    logic signed [RW_W-1:0] w_added;
    logic                   w_take;
    logic                   r_valid;
    t_token                 r_token;
    t_token                 n_token;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    assign w_added = sat_rw((RW_W+1)'(r_rw) + (RW_W+1)'(i_weight));
    assign w_take  = i_valid && i_in_use && i_healthy;

    always_comb begin
        n_token = i_token;
        if (w_take) begin
            n_token.total = i_token.total + TOT_W'(i_weight);
            if (!i_token.found || (w_added > i_token.best_val)) begin
                n_token.found    = 1'b1;
                n_token.best_val = w_added;
                n_token.best_idx = MY_IDX;
            end
        end
    end

    always_comb begin
        n_rw = r_rw;
        if (i_clear) begin
            n_rw = '0;
        end else if (w_take) begin
            n_rw = w_added;
        end else if (i_apply.en && (i_apply.idx == MY_IDX)) begin
            n_rw = sat_rw((RW_W+1)'(r_rw) - (RW_W+1)'({1'b0, i_apply.total}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rw    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_rw    <= n_rw;
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_token <= n_token;
    end

    assign o_valid = r_valid;
    assign o_token = r_token;

endmodule

`default_nettype wire

>>> sv/smooth_weighted_round_robin.sv
// Top level of the smooth weighted round-robin selector: config, scan control and result register.
//
// Usage:
//   Request channel: i_valid / o_stall with i_healthy_mask (bit i = target i healthy).
//   Result channel:  o_valid / i_stall with o_chosen_target and o_status
//   (0 ok, 1 no targets configured, 2 no healthy target; target is 0 unless ok).
//   Config: i_cfg_we writes register i_cfg_index (0 weights, 1 target_count) from
//   i_cfg_data; a write to either register clears all running weights.
// Operation:
//   A request walks a row of NUM_TARGETS cells, one cell per cycle, then the
//   winner's running weight is reduced and the result passes through a result
//   register to the output register. No new request is taken until the result
//   has been moved to the output register.
// Reset:
//   Synchronous, active low. Weights all 1, target_count 8, running weights 0,
//   no result pending.
// Stall:
//   The result is held in an output register while i_stall is high; a new
//   request may already be accepted and scanned meanwhile, and it waits for
//   the output register to drain before its result is shown.
`default_nettype none

module smooth_weighted_round_robin
    import swrr_pkg::*;
#(
    parameter int NUM_TARGETS = 8,
    parameter int WEIGHT_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [7:0]           i_healthy_mask,
    // result channel
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [IDX_W-1:0]          o_chosen_target,
    output logic [ST_W-1:0]           o_status,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]       r_weights;
    logic [3:0]             r_count;
    logic [NUM_TARGETS-1:0] r_mask;
    logic                   r_start;
    logic                   r_out_valid;
    logic [IDX_W-1:0]       r_out_target;
    logic [ST_W-1:0]        r_out_status;
    logic [IDX_W-1:0]       r_res_target;
    logic [ST_W-1:0]        r_res_status;

    logic                   w_accept;
    logic                   w_clear;
    logic                   w_last;
    logic                   w_load;
    t_token                 w_final;
    t_apply                 w_apply;
    logic [IDX_W-1:0]       w_target;
    logic [ST_W-1:0]        w_status;

    t_token                 w_tok [0:NUM_TARGETS];
    logic [NUM_TARGETS:0]   w_vld;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign w_clear  = i_cfg_we &&
                      ((i_cfg_index == REG_WEIGHTS) || (i_cfg_index == REG_TARGET_COUNT));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights <= WEIGHTS_RST;
            r_count   <= COUNT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_WEIGHTS) begin
                r_weights <= i_cfg_data;
            end else if (i_cfg_index == REG_TARGET_COUNT) begin
                r_count <= i_cfg_data[3:0];
            end
        end
    end

    // mask is held for the whole scan
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mask <= i_healthy_mask[NUM_TARGETS-1:0];
        end
    end

    // cell row: token enters cell 0 the cycle after acceptance
    assign w_tok[0] = '{found: 1'b0, best_val: '0, best_idx: '0, total: '0};
    assign w_vld[0] = r_start;

    for (genvar g = 0; g < NUM_TARGETS; g++) begin : g_cell
        swrr_cell #(
            .WEIGHT_BITS (WEIGHT_BITS),
            .INDEX       (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clear   (w_clear),
            .i_weight  (r_weights[8*g +: WEIGHT_BITS]),
            // count above NUM_TARGETS simply enables every cell
            .i_in_use  (r_count > 4'(g)),
            .i_healthy (r_mask[g]),
            .i_valid   (w_vld[g]),
            .i_token   (w_tok[g]),
            .i_apply   (w_apply),
            .o_valid   (w_vld[g+1]),
            .o_token   (w_tok[g+1])
        );
    end

    assign w_last  = w_vld[NUM_TARGETS];
    assign w_final = w_tok[NUM_TARGETS];

    // result decode for the token leaving the last cell
    always_comb begin
        w_target = '0;
        if (r_count == '0) begin
            w_status = ST_NO_TARGETS;
        end else if (!w_final.found) begin
            w_status = ST_NO_HEALTHY;
        end else begin
            w_status = ST_OK;
            w_target = w_final.best_idx;
        end
    end

    // winner pays back the healthy total
    assign w_apply.en    = w_last && (r_count != '0) && w_final.found;
    assign w_apply.idx   = w_final.best_idx;
    assign w_apply.total = w_final.total;

    assign w_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last) begin
            r_res_target <= w_target;
            r_res_status <= w_status;
        end
        if (w_load) begin
            r_out_target <= r_res_target;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_chosen_target = r_out_target;
    assign o_status        = r_out_status;

    // at most one token in the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("more than one token in the cell row");

    // tokens only travel during a scan
    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld != '0) |-> (r_state == S_SCAN))
        else $error("token in flight outside a scan");

    // a winner update closes the scan
    a_apply_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_apply.en |=> (r_state == S_DONE))
        else $error("winner update without scan completion");

    // failed selections report target zero
    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_chosen_target == '0))
        else $error("nonzero target with error status");

endmodule

`default_nettype wire
